// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: shared types and constants of the text console writer
// word layouts of both channels, the front-to-back op word, char codes
// no dependencies
package tcw_pkg;

   // request modes
   localparam logic [1:0] MODE_CHAR  = 2'd0;
   localparam logic [1:0] MODE_HEX   = 2'd1;
   localparam logic [1:0] MODE_DEC   = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   // control characters
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   // hex expansion: eight nibbles
   localparam int unsigned NIB_W = 3;
   localparam logic [NIB_W-1:0] NIB_LAST = 3'd7;

   // decimal expansion: up to ten digits, divide by ten via reciprocal
   localparam int unsigned DEC_DIGITS = 10;
   localparam int unsigned DIG_CNT_W  = 4;
   localparam logic [63:0] DEC_RECIP  = 64'h0000_0000_CCCC_CCCD;
   localparam int unsigned DEC_SHIFT  = 35;

   // op queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic        clear_all;
      logic        write_cell;
      logic [10:0] cell_index;
      logic [7:0]  char_code;
      logic [11:0] cursor_pos;
      logic        last;
   } rsp_payload_type;

   // one character (or a clear) for the back end
   typedef struct packed {
      logic       is_clear;
      logic       last;
      logic [7:0] code;
   } op_type;

   function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         hex_glyph = CHAR_ZERO + wide;
      end else begin
         hex_glyph = 8'h37 + wide;
      end
   endfunction

endpackage

// ----- rtl/tcw_stream_if.sv -----
// tcw_stream_if: valid/ready channel carrying one word of payload_type
// payload types come from tcw_pkg at the point of instantiation
interface tcw_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/text_console_writer_unit.sv -----
// text_console_writer_unit: text console engine on a COLUMNS x ROWS grid
// back end: one response word per character or clear, a clear word first when it scrolls;
// front: a character or clear is taken every cycle while the queue has room, hex holds
// the front for one nibble per cycle while the queue has room, decimal through a multiply
// and a subtract state per digit (divide by ten via the reciprocal), then emits the digits
// most significant first; the response word is registered in the back end behind the queue
// synchronous reset: cursor to the top left, queue and response empty
module text_console_writer_unit #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   tcw_stream_if.sink   req_ch,
   tcw_stream_if.source rsp_ch
);

   // front to queue
   logic            front_push;
   tcw_pkg::op_type front_op;
   logic            queue_full;

   // queue to back
   logic            back_pop;
   logic            queue_not_empty;
   tcw_pkg::op_type head_op;

   logic                     req_ready;
   logic                     rsp_valid;
   tcw_pkg::rsp_payload_type rsp_payload;

   // front: decodes the request word, expands numbers into digit chars
   tcw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_payload (req_ch.payload),
      .req_ready   (req_ready),
      .q_full      (queue_full),
      .q_push      (front_push),
      .q_op        (front_op)
   );

   // small queue so the digit expander and the cursor engine stall apart
   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_op   (front_op),
      .full      (queue_full),
      .pop       (back_pop),
      .not_empty (queue_not_empty),
      .head_op   (head_op)
   );

   // back: cursor wrap, scroll clear, control chars, cell writes
   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (queue_not_empty),
      .op          (head_op),
      .op_pop      (back_pop),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // response word is registered inside the back end
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

endmodule

// ----- rtl/tcw_front.sv -----
// tcw_front: accepts request words and expands them into character ops
// depends on tcw_pkg (modes, op_type, glyphs, reciprocal constants)
module tcw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tcw_pkg::req_payload_type req_payload,
   output logic                 req_ready,
   input  logic                 q_full,
   output logic                 q_push,
   output tcw_pkg::op_type      q_op
);

   typedef enum logic [4:0] {
      FR_IDLE = 5'b00001,
      FR_HEX  = 5'b00010,
      FR_MUL  = 5'b00100,
      FR_SUB  = 5'b01000,
      FR_EMIT = 5'b10000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [31:0] val_ff, val_in;
   logic [63:0] prod_ff, prod_in;
   logic [tcw_pkg::NIB_W-1:0] nib_cnt_ff, nib_cnt_in;
   logic started_ff, started_in;
   logic [tcw_pkg::DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic [3:0] digit_ff [tcw_pkg::DEC_DIGITS];

   logic [3:0] nib;
   logic hex_emit;
   logic [28:0] quot;
   logic [32:0] quot10;
   logic [3:0] rem;
   logic [tcw_pkg::DIG_CNT_W-1:0] dig_idx;

   assign nib      = val_ff[31:28];
   assign hex_emit = started_ff || (nib != 4'd0) || (nib_cnt_ff == tcw_pkg::NIB_LAST);
   assign quot     = prod_ff[63:tcw_pkg::DEC_SHIFT];
   assign quot10   = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
   assign rem      = val_ff[3:0] - quot10[3:0];
   assign dig_idx  = dig_cnt_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      val_in     = val_ff;
      prod_in    = prod_ff;
      nib_cnt_in = nib_cnt_ff;
      started_in = started_ff;
      dig_cnt_in = dig_cnt_ff;
      q_push     = 1'b0;
      q_op       = '0;
      req_ready  = (state_ff == FR_IDLE) && !q_full;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_valid && !q_full) begin
               unique case (req_payload.mode)
                  tcw_pkg::MODE_CHAR: begin
                     q_push = 1'b1;
                     q_op   = '{is_clear: 1'b0, last: 1'b1, code: req_payload.value[7:0]};
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     q_push = 1'b1;
                     q_op   = '{is_clear: 1'b1, last: 1'b1, code: 8'h00};
                  end
                  tcw_pkg::MODE_HEX: begin
                     val_in     = req_payload.value;
                     nib_cnt_in = '0;
                     started_in = 1'b0;
                     state_in   = FR_HEX;
                  end
                  tcw_pkg::MODE_DEC: begin
                     val_in     = req_payload.value;
                     dig_cnt_in = '0;
                     state_in   = FR_MUL;
                  end
               endcase
            end
         end
         FR_HEX: begin
            // skip leading zeros, but the last nibble always prints
            if (!(hex_emit && q_full)) begin
               q_push     = hex_emit;
               q_op       = '{is_clear: 1'b0,
                              last: (nib_cnt_ff == tcw_pkg::NIB_LAST),
                              code: tcw_pkg::hex_glyph(nib)};
               started_in = started_ff || hex_emit;
               val_in     = {val_ff[27:0], 4'h0};
               nib_cnt_in = nib_cnt_ff + 1'b1;
               if (nib_cnt_ff == tcw_pkg::NIB_LAST) begin
                  state_in = FR_IDLE;
               end
            end
         end
         FR_MUL: begin
            prod_in  = {32'h0, val_ff} * tcw_pkg::DEC_RECIP;
            state_in = FR_SUB;
         end
         FR_SUB: begin
            // digits collect least significant first
            val_in     = {3'b000, quot};
            dig_cnt_in = dig_cnt_ff + 1'b1;
            state_in   = (quot == 29'd0) ? FR_EMIT : FR_MUL;
         end
         FR_EMIT: begin
            if (!q_full) begin
               q_push     = 1'b1;
               q_op       = '{is_clear: 1'b0,
                              last: (dig_cnt_ff == 4'd1),
                              code: tcw_pkg::CHAR_ZERO + {4'h0, digit_ff[dig_idx]}};
               dig_cnt_in = dig_idx;
               if (dig_cnt_ff == 4'd1) begin
                  state_in = FR_IDLE;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_IDLE;
         nib_cnt_ff <= '0;
         started_ff <= 1'b0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         nib_cnt_ff <= nib_cnt_in;
         started_ff <= started_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      prod_ff <= prod_in;
      if (state_ff == FR_SUB) begin
         digit_ff[dig_cnt_ff] <= rem;
      end
   end

`ifndef ASSERT_OFF
   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      state_ff == FR_EMIT |-> dig_cnt_ff != '0)
      else $error("decimal emit with empty digit store");
`endif

endmodule

// ----- rtl/tcw_queue.sv -----
// tcw_queue: short op queue between front and back
// depends on tcw_pkg (op_type, QUEUE_DEPTH)
module tcw_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tcw_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output tcw_pkg::op_type head_op
);

   localparam int unsigned DEPTH = tcw_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tcw_pkg::op_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("op queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("op queue underflow");
`endif

endmodule

// ----- rtl/tcw_back.sv -----
// tcw_back: cursor engine, turns character ops into response words
// depends on tcw_pkg (op_type, rsp_payload_type, control chars)
module tcw_back #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   input  tcw_pkg::op_type          op,
   output logic                     op_pop,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output tcw_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned COL_W = $clog2(COLUMNS + 8);
   localparam int unsigned ROW_W = $clog2(ROWS + 1);
   localparam int unsigned POS_W = COL_W + ROW_W + 1;

   logic [COL_W-1:0] col_ff, col_in, col_w;
   logic [ROW_W-1:0] row_ff, row_in, row_w;
   logic rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_payload_type rsp_pay_ff, rsp_pay_in;

   logic can_load;
   logic wrap_clear;
   logic [COL_W-1:0] col_tab;

   function automatic logic [POS_W-1:0] grid_pos(input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] r);
      grid_pos = POS_W'(r) * POS_W'(COLUMNS) + POS_W'(c);
   endfunction

   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      col_w = col_ff;
      row_w = row_ff;
      if (col_ff > COL_W'(COLUMNS - 1)) begin
         col_w = '0;
         row_w = row_ff + 1'b1;
      end
   end

   assign wrap_clear = (row_w > ROW_W'(ROWS - 1));
   assign col_tab    = (col_w + COL_W'(8)) & ~COL_W'(7);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      op_pop       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pay_in   = rsp_pay_ff;
      if (can_load && op_valid) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in   = '0;
         if (op.is_clear) begin
            rsp_pay_in.clear_all  = 1'b1;
            rsp_pay_in.cursor_pos = 12'(grid_pos(col_ff, row_ff));
            rsp_pay_in.last       = op.last;
            op_pop                = 1'b1;
         end else if (wrap_clear) begin
            // scrolled past the bottom: clear first, op stays at the head
            rsp_pay_in.clear_all  = 1'b1;
            rsp_pay_in.cursor_pos = 12'(grid_pos(col_w, '0));
            col_in                = col_w;
            row_in                = '0;
         end else begin
            op_pop = 1'b1;
            rsp_pay_in.last = op.last;
            case (op.code)
               tcw_pkg::CHAR_CR: begin
                  col_in = '0;
                  row_in = row_w;
               end
               tcw_pkg::CHAR_LF: begin
                  col_in = '0;
                  row_in = row_w + 1'b1;
               end
               tcw_pkg::CHAR_BS: begin
                  col_in = (col_w != '0) ? col_w - 1'b1 : col_w;
                  row_in = row_w;
               end
               tcw_pkg::CHAR_TAB: begin
                  col_in = col_tab;
                  row_in = row_w;
               end
               default: begin
                  col_in = col_w + 1'b1;
                  row_in = row_w;
                  rsp_pay_in.write_cell = 1'b1;
                  rsp_pay_in.cell_index = 11'(grid_pos(col_w, row_w));
                  rsp_pay_in.char_code  = op.code;
               end
            endcase
            rsp_pay_in.cursor_pos = 12'(grid_pos(col_in, row_in));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pay_ff <= rsp_pay_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_pay_ff;

`ifndef ASSERT_OFF
   a_clear_writes_nothing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pay_ff.clear_all |-> !rsp_pay_ff.write_cell)
      else $error("clear word also writes a cell");
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_W'(ROWS) && col_ff < COL_W'(COLUMNS + 8))
      else $error("cursor out of range");
   a_wrap_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      can_load && op_valid && !op.is_clear && wrap_clear |=> row_ff == '0)
      else $error("scroll clear left the cursor off row zero");
`endif

endmodule
